// File: sv/abd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abd_pkg
// Shared types, widths and register indexes for the anchor box decoder.
// ----------------------------------------------------------------------------
package abd_pkg;

    localparam int DIST_BITS = 16;
    localparam int FRAC_BITS = 4;
    localparam int CNT_W     = 8;
    localparam int LEV_W     = 2;
    localparam int BOX_W     = 23;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;
    localparam int NUM_LEV   = 3;

    // anchor point: (count << FRAC_BITS) + half cell
    localparam int AX_W  = CNT_W + FRAC_BITS + 1;
    localparam int CW    = ((AX_W > DIST_BITS) ? AX_W : DIST_BITS) + 2;
    localparam int SW    = CW + 1;
    localparam int SCW   = ((SW + 5) > (BOX_W + 1)) ? (SW + 5) : (BOX_W + 1);
    localparam int HALF_CELL = (1 << FRAC_BITS) >> 1;
    localparam int STRIDE_LOG2_BASE = 3;

    localparam logic [LEV_W-1:0] LAST_LEVEL = LEV_W'(NUM_LEV - 1);

    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL0_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL0_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL1_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL1_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL2_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL2_HEIGHT = 3'd6;

    localparam logic signed [SCW-1:0] SAT_HI = SCW'((1 << (BOX_W - 1)) - 1);
    localparam logic signed [SCW-1:0] SAT_LO = -SCW'(1 << (BOX_W - 1));

    typedef struct packed {
        logic signed [DIST_BITS-1:0] dist_left;
        logic signed [DIST_BITS-1:0] dist_top;
        logic signed [DIST_BITS-1:0] dist_right;
        logic signed [DIST_BITS-1:0] dist_bottom;
    } dist_in_t;

    typedef struct packed {
        logic signed [BOX_W-1:0] box_first;
        logic signed [BOX_W-1:0] box_second;
        logic signed [BOX_W-1:0] box_third;
        logic signed [BOX_W-1:0] box_fourth;
        logic [LEV_W-1:0]        pyramid_level;
        logic                    frame_last;
    } box_out_t;

    typedef struct packed {
        logic                             output_mode;
        logic [NUM_LEV-1:0][CNT_W-1:0]    level_width;
        logic [NUM_LEV-1:0][CNT_W-1:0]    level_height;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] column;
        logic [CNT_W-1:0] row;
        logic [LEV_W-1:0] level;
        logic             last;
    } anchor_t;

    function automatic logic signed [BOX_W-1:0] sat_box(input logic signed [SCW-1:0] v);
        logic signed [BOX_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[BOX_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[BOX_W-1:0];
        end
        else
        begin
            r = v[BOX_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: sv/abd_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abd_cfg_regs
// Configuration register file: output mode and per-level grid sizes.
// ----------------------------------------------------------------------------
module abd_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [abd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [abd_pkg::CFG_DAT_W-1:0] cfg_data,
    output abd_pkg::cfg_t                      cfg
);
    import abd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OUTPUT_MODE:   cfg_next.output_mode     = cfg_data[0];
                REG_LEVEL0_WIDTH:  cfg_next.level_width[0]  = cfg_data;
                REG_LEVEL0_HEIGHT: cfg_next.level_height[0] = cfg_data;
                REG_LEVEL1_WIDTH:  cfg_next.level_width[1]  = cfg_data;
                REG_LEVEL1_HEIGHT: cfg_next.level_height[1] = cfg_data;
                REG_LEVEL2_WIDTH:  cfg_next.level_width[2]  = cfg_data;
                REG_LEVEL2_HEIGHT: cfg_next.level_height[2] = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.output_mode     <= 1'b1;
            cfg_reg.level_width[0]  <= 8'd80;
            cfg_reg.level_height[0] <= 8'd80;
            cfg_reg.level_width[1]  <= 8'd40;
            cfg_reg.level_height[1] <= 8'd40;
            cfg_reg.level_width[2]  <= 8'd20;
            cfg_reg.level_height[2] <= 8'd20;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// File: sv/abd_anchor_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abd_anchor_counter
// Column, row and level counters; reports the current anchor and frame end.
// ----------------------------------------------------------------------------
module abd_anchor_counter (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    advance,
    input  abd_pkg::cfg_t cfg,
    output abd_pkg::anchor_t anchor
);
    import abd_pkg::*;

    logic [CNT_W-1:0] column_reg, column_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [LEV_W-1:0] level_reg, level_next;
    logic [LEV_W-1:0] lev;
    logic [1:0]       lev_idx;
    logic [CNT_W-1:0] w_eff, h_eff;
    logic             last_col, last_row;

    always_comb
    begin
        lev      = (level_reg > LAST_LEVEL) ? LAST_LEVEL : level_reg;
        lev_idx  = lev;
        w_eff    = (cfg.level_width[lev_idx] == '0) ? CNT_W'(1) : cfg.level_width[lev_idx];
        h_eff    = (cfg.level_height[lev_idx] == '0) ? CNT_W'(1) : cfg.level_height[lev_idx];
        // at or past bound counts as last
        last_col = ({1'b0, column_reg} + (CNT_W+1)'(1)) >= {1'b0, w_eff};
        last_row = ({1'b0, row_reg} + (CNT_W+1)'(1)) >= {1'b0, h_eff};

        column_next = column_reg;
        row_next    = row_reg;
        level_next  = level_reg;
        if (!last_col)
        begin
            column_next = column_reg + CNT_W'(1);
        end
        else
        begin
            column_next = '0;
            if (!last_row)
            begin
                row_next = row_reg + CNT_W'(1);
            end
            else
            begin
                row_next   = '0;
                level_next = (lev == LAST_LEVEL) ? '0 : lev + LEV_W'(1);
            end
        end

        anchor.column = column_reg;
        anchor.row    = row_reg;
        anchor.level  = lev;
        anchor.last   = last_col && last_row && (lev == LAST_LEVEL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
            level_reg  <= '0;
        end
        else if (advance)
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
            level_reg  <= level_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/abd_box_math.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abd_box_math
// Anchor point, corners or center/size, stride scaling and saturation.
// ----------------------------------------------------------------------------
module abd_box_math (
    input  abd_pkg::dist_in_t dist_data,
    input  abd_pkg::anchor_t  anchor,
    input  wire logic         output_mode,
    output abd_pkg::box_out_t box
);
    import abd_pkg::*;

    logic [AX_W-1:0]        ax, ay;
    logic signed [CW-1:0]   x1, y1, x2, y2;
    logic signed [SW-1:0]   a, b, c, d;
    logic [2:0]             shamt;

    always_comb
    begin
        ax = (AX_W'(anchor.column) << FRAC_BITS) + AX_W'(HALF_CELL);
        ay = (AX_W'(anchor.row) << FRAC_BITS) + AX_W'(HALF_CELL);
        x1 = CW'(signed'({1'b0, ax})) - CW'(dist_data.dist_left);
        y1 = CW'(signed'({1'b0, ay})) - CW'(dist_data.dist_top);
        x2 = CW'(signed'({1'b0, ax})) + CW'(dist_data.dist_right);
        y2 = CW'(signed'({1'b0, ay})) + CW'(dist_data.dist_bottom);

        if (output_mode)
        begin
            // arithmetic shift gives floor halving
            a = (SW'(x1) + SW'(x2)) >>> 1;
            b = (SW'(y1) + SW'(y2)) >>> 1;
            c = SW'(x2) - SW'(x1);
            d = SW'(y2) - SW'(y1);
        end
        else
        begin
            a = SW'(x1);
            b = SW'(y1);
            c = SW'(x2);
            d = SW'(y2);
        end

        shamt = {1'b0, anchor.level} + 3'(STRIDE_LOG2_BASE);

        box.box_first     = sat_box(SCW'(a) <<< shamt);
        box.box_second    = sat_box(SCW'(b) <<< shamt);
        box.box_third     = sat_box(SCW'(c) <<< shamt);
        box.box_fourth    = sat_box(SCW'(d) <<< shamt);
        box.pyramid_level = anchor.level;
        box.frame_last    = anchor.last;
    end

endmodule
`default_nettype wire

// File: sv/anchor_box_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anchor_box_decoder
// Turns per-anchor edge distances into pixel boxes across three pyramid levels.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  input     in_valid / in_ready / in_data    dist_in_t in
//  output    out_valid / out_ready / out_data box_out_t out
//  config    cfg_we / cfg_index / cfg_data    write only
//
//  One transfer per cycle in each direction while the output is not stalled;
//  data passes the input register, then the result register after the box math.
//  Counters advance on each input transfer; reset returns to level 0,
//  row 0, column 0 and register defaults.
//  A stalled output holds both full stages; in_ready = !s1_valid || out_advance.
// ----------------------------------------------------------------------------
module anchor_box_decoder (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  abd_pkg::dist_in_t                  in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output abd_pkg::box_out_t                  out_data,
    input  wire logic                          cfg_we,
    input  wire logic [abd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [abd_pkg::CFG_DAT_W-1:0] cfg_data
);
    import abd_pkg::*;

    cfg_t     cfg;
    anchor_t  anchor;
    box_out_t box;

    dist_in_t s1_dist_reg;
    anchor_t  s1_anchor_reg;
    logic     s1_valid_reg;
    box_out_t out_data_reg;
    logic     out_valid_reg;

    logic     out_advance;
    logic     in_xfer;

    abd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    abd_anchor_counter u_counter (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (in_xfer),
        .cfg     (cfg),
        .anchor  (anchor)
    );

    abd_box_math u_math (
        .dist_data   (s1_dist_reg),
        .anchor      (s1_anchor_reg),
        .output_mode (cfg.output_mode),
        .box         (box)
    );

    assign out_advance = !out_valid_reg || out_ready;
    assign in_ready    = !s1_valid_reg || out_advance;
    assign in_xfer     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_dist_reg   <= in_data;
            s1_anchor_reg <= anchor;
        end
        if (out_advance && s1_valid_reg)
        begin
            out_data_reg <= box;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// File: tb/anchor_box_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anchor_box_checker
// Watches the distance, box and register channels of the anchor box decoder.
// Keeps its own grid counters and register copy, predicts the box for every
// input transfer and compares each output transfer, field by field, with the
// oldest predicted box.
// ----------------------------------------------------------------------------
module anchor_box_checker
    import abd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  dist_in_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  box_out_t             out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output int                   mismatch_count,
    output int                   boxes_pending
);

    localparam int MAX_REPORTS = 50;

    logic             center_mode;
    logic [CNT_W-1:0] grid_width  [NUM_LEV];
    logic [CNT_W-1:0] grid_height [NUM_LEV];
    logic [CNT_W-1:0] col_cnt;
    logic [CNT_W-1:0] row_cnt;
    logic [LEV_W-1:0] lev_cnt;
    box_out_t         expected_boxes[$];

    function automatic logic signed [BOX_W-1:0] clamp_box(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (BOX_W - 1)) - 1;
        lo = -(longint'(1) <<< (BOX_W - 1));
        if (v > hi)
        begin
            v = hi;
        end
        else if (v < lo)
        begin
            v = lo;
        end
        return v[BOX_W-1:0];
    endfunction

    // predicts one box and advances the grid position
    function automatic box_out_t decode_anchor(input dist_in_t d);
        box_out_t    b;
        int unsigned lev;
        int unsigned w;
        int unsigned h;
        longint      ax;
        longint      ay;
        longint      x1;
        longint      y1;
        longint      x2;
        longint      y2;
        longint      stride;
        longint      v [4];
        bit          last_col;
        bit          last_row;
        bit          last;
        lev = (lev_cnt > LAST_LEVEL) ? int'(LAST_LEVEL) : int'(lev_cnt);
        w   = (grid_width[lev] == '0) ? 1 : int'(grid_width[lev]);
        h   = (grid_height[lev] == '0) ? 1 : int'(grid_height[lev]);
        ax  = ((longint'(col_cnt) * 2 + 1) <<< FRAC_BITS) / 2;
        ay  = ((longint'(row_cnt) * 2 + 1) <<< FRAC_BITS) / 2;
        x1  = ax - longint'(d.dist_left);
        y1  = ay - longint'(d.dist_top);
        x2  = ax + longint'(d.dist_right);
        y2  = ay + longint'(d.dist_bottom);
        stride = longint'(8) <<< lev;
        if (center_mode)
        begin
            v[0] = (x1 + x2) >>> 1;
            v[1] = (y1 + y2) >>> 1;
            v[2] = x2 - x1;
            v[3] = y2 - y1;
        end
        else
        begin
            v[0] = x1;
            v[1] = y1;
            v[2] = x2;
            v[3] = y2;
        end
        last_col = (int'(col_cnt) + 1) >= w;
        last_row = (int'(row_cnt) + 1) >= h;
        last     = last_col && last_row && (lev == int'(LAST_LEVEL));
        b.box_first     = clamp_box(v[0] * stride);
        b.box_second    = clamp_box(v[1] * stride);
        b.box_third     = clamp_box(v[2] * stride);
        b.box_fourth    = clamp_box(v[3] * stride);
        b.pyramid_level = LEV_W'(lev);
        b.frame_last    = last;
        if (!last_col)
        begin
            col_cnt = col_cnt + 1'b1;
        end
        else
        begin
            col_cnt = '0;
            if (!last_row)
            begin
                row_cnt = row_cnt + 1'b1;
            end
            else
            begin
                row_cnt = '0;
                lev_cnt = (lev == int'(LAST_LEVEL)) ? '0 : LEV_W'(lev + 1);
            end
        end
        return b;
    endfunction

    task automatic check_field(input string name, input logic signed [BOX_W-1:0] expv,
                               input logic signed [BOX_W-1:0] actv);
        if (expv !== actv)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s expected %0d, got %0d", $time, name, expv, actv);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        box_out_t want;
        if (!rst_n)
        begin
            center_mode    = 1'b1;
            grid_width[0]  = 8'd80;
            grid_height[0] = 8'd80;
            grid_width[1]  = 8'd40;
            grid_height[1] = 8'd40;
            grid_width[2]  = 8'd20;
            grid_height[2] = 8'd20;
            col_cnt        = '0;
            row_cnt        = '0;
            lev_cnt        = '0;
            mismatch_count = 0;
            expected_boxes.delete();
            boxes_pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OUTPUT_MODE:   center_mode    = cfg_data[0];
                    REG_LEVEL0_WIDTH:  grid_width[0]  = cfg_data;
                    REG_LEVEL0_HEIGHT: grid_height[0] = cfg_data;
                    REG_LEVEL1_WIDTH:  grid_width[1]  = cfg_data;
                    REG_LEVEL1_HEIGHT: grid_height[1] = cfg_data;
                    REG_LEVEL2_WIDTH:  grid_width[2]  = cfg_data;
                    REG_LEVEL2_HEIGHT: grid_height[2] = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_boxes.push_back(decode_anchor(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_boxes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: box transfer with none expected, got %p", $time,
                                 out_data);
                end
                else
                begin
                    want = expected_boxes.pop_front();
                    check_field("box_first", want.box_first, out_data.box_first);
                    check_field("box_second", want.box_second, out_data.box_second);
                    check_field("box_third", want.box_third, out_data.box_third);
                    check_field("box_fourth", want.box_fourth, out_data.box_fourth);
                    check_field("pyramid_level", want.pyramid_level, out_data.pyramid_level);
                    check_field("frame_last", want.frame_last, out_data.frame_last);
                end
            end
            boxes_pending <= expected_boxes.size();
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the anchor box decoder: directed distance extremes and grid
// corner cases, then random distances over many small grid settings with
// random gaps and output stalls, one long output hold-off and a quiet tail.
// ----------------------------------------------------------------------------
module tb;
    import abd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 120;
    localparam int ITEM_TARGET    = 1300;
    localparam int QUIET_TAIL     = 150;
    localparam int HOLD_AT        = 400;

    localparam logic signed [DIST_BITS-1:0] DMAX = {1'b0, {(DIST_BITS-1){1'b1}}};
    localparam logic signed [DIST_BITS-1:0] DMIN = {1'b1, {(DIST_BITS-1){1'b0}}};
    localparam logic signed [DIST_BITS-1:0] DZERO = '0;
    localparam logic signed [DIST_BITS-1:0] DONE = DIST_BITS'(1);

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    dist_in_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    box_out_t             out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    int mismatch_count;
    int boxes_pending;
    int items_sent  = 0;
    int idle_cycles = 0;
    bit gaps_on      = 1'b0;
    bit stalls_on    = 1'b0;
    bit hold_request = 1'b0;
    bit hold_done    = 1'b0;

    always #1 clk = ~clk;

    anchor_box_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    anchor_box_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .boxes_pending  (boxes_pending)
    );

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // box receiver
    initial
    begin
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    function automatic logic signed [DIST_BITS-1:0] rand_dist();
        logic signed [DIST_BITS-1:0] r;
        case ($urandom_range(0, 5))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       r = DMIN;
                    1:       r = DMAX;
                    2:       r = DZERO;
                    3:       r = '1;
                    default: r = DONE;
                endcase
            end
            1, 2:    r = DIST_BITS'(int'($urandom_range(0, 256)) - 128);
            default: r = DIST_BITS'($urandom);
        endcase
        return r;
    endfunction

    function automatic dist_in_t rand_anchor();
        dist_in_t d;
        d.dist_left   = rand_dist();
        d.dist_top    = rand_dist();
        d.dist_right  = rand_dist();
        d.dist_bottom = rand_dist();
        return d;
    endfunction

    function automatic logic [CNT_W-1:0] rand_dim();
        logic [CNT_W-1:0] r;
        case ($urandom_range(0, 19))
            0:       r = '0;
            1:       r = CNT_W'($urandom_range(6, 12));
            default: r = CNT_W'($urandom_range(1, 4));
        endcase
        return r;
    endfunction

    task automatic send_anchor(input dist_in_t d);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic drain_decoder();
        in_valid <= 1'b0;
        @(posedge clk);
        while (boxes_pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic program_decoder(input logic mode,
                                   input logic [CNT_W-1:0] w0, input logic [CNT_W-1:0] h0,
                                   input logic [CNT_W-1:0] w1, input logic [CNT_W-1:0] h1,
                                   input logic [CNT_W-1:0] w2, input logic [CNT_W-1:0] h2);
        drain_decoder();
        write_reg(REG_OUTPUT_MODE, CFG_DAT_W'(mode));
        write_reg(REG_LEVEL0_WIDTH, w0);
        write_reg(REG_LEVEL0_HEIGHT, h0);
        write_reg(REG_LEVEL1_WIDTH, w1);
        write_reg(REG_LEVEL1_HEIGHT, h1);
        write_reg(REG_LEVEL2_WIDTH, w2);
        write_reg(REG_LEVEL2_HEIGHT, h2);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: center mode, full-size grids
        send_anchor(dist_in_t'{DZERO, DZERO, DZERO, DZERO});
        send_anchor(dist_in_t'{DMAX, DMAX, DMAX, DMAX});
        send_anchor(dist_in_t'{DMIN, DMIN, DMIN, DMIN});
        send_anchor(dist_in_t'{DMIN, DMAX, DMIN, DMAX});
        send_anchor(dist_in_t'{DMAX, DMIN, DMAX, DMIN});
        // odd negative and odd positive sums for the halving
        send_anchor(dist_in_t'{DMAX, DMAX, DZERO, DZERO});
        send_anchor(dist_in_t'{DONE, DONE, DZERO, DZERO});

        program_decoder(1'b0, 8'd80, 8'd80, 8'd40, 8'd40, 8'd20, 8'd20);
        send_anchor(dist_in_t'{DMIN, DMAX, DMIN, DMAX});
        send_anchor(dist_in_t'{DMAX, DMIN, DMAX, DMIN});
        send_anchor(dist_in_t'{'1, '1, '1, '1});

        // column counter now past a one-cell grid
        program_decoder(1'b0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
        repeat (6) send_anchor(rand_anchor());

        // zero sizes act as one
        program_decoder(1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        repeat (4) send_anchor(rand_anchor());

        // widest row and tallest column
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        program_decoder(1'($urandom_range(0, 1)), 8'd255, 8'd1, 8'd1, 8'd1, 8'd1, 8'd255);
        repeat (511) send_anchor(rand_anchor());

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent > ITEM_TARGET - QUIET_TAIL)
            begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            else
            begin
                gaps_on   = ($urandom_range(0, 4) != 0);
                stalls_on = ($urandom_range(0, 4) != 0);
            end
            program_decoder(1'($urandom_range(0, 1)), rand_dim(), rand_dim(), rand_dim(),
                            rand_dim(), rand_dim(), rand_dim());
            n = $urandom_range(15, 90);
            repeat (n)
            begin
                if (!hold_done && items_sent >= HOLD_AT)
                begin
                    hold_request = 1'b1;
                    hold_done    = 1'b1;
                end
                send_anchor(rand_anchor());
            end
        end

        drain_decoder();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && boxes_pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
